// File: hw/rtl/ipfr_pkg.sv
// Shared types and constants for the IPv4 fragment reassembly tracker.
`timescale 1ns / 1ps
package ipfr_pkg;

	localparam int BLK_W = 15;
	localparam int LEN_W = 16;
	localparam int HW_W  = 4;

	localparam logic OP_LOG   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		STS_STORED       = 3'd0,
		STS_COMPLETE     = 3'd1,
		STS_TABLE_FULL   = 3'd2,
		STS_TOO_LONG     = 3'd3,
		STS_NOT_FOUND    = 3'd4,
		STS_NOT_COMPLETE = 3'd5,
		STS_Q_COMPLETE   = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_UPDATE,
		S_RD,
		S_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             alloc;
		logic             set_pe;
		logic             set_fhw;
		logic             set_ls;
		logic [LEN_W-1:0] pe_val;
		logic [HW_W-1:0]  fhw_val;
	} slot_ctl_t;

endpackage

// File: hw/rtl/ip_fragment_reassembly_tracker.sv
// Top level: sequencer and shared bitmap word unit of the fragment reassembly tracker.
//
//   channel  signals                                            direction
//   in       in_valid/in_ready, opcode .. more_fragments        into block
//   out      out_valid/out_ready, status .. reassembled_length  out of block
//
// An item passes through accept, lookup, update, the bitmap pass, a final check and done;
// the pass reads each bitmap word and then ors in and checks it, up to the last word
// marked or checked; a word wholly below the fragment and past the check range is skipped
// without a read. Not found, table full and too long end after lookup.
// Reset clears slot valid bits and per-word bitmap valid bits at once, no sweep.
// A finished result waits in the output register; the next item is taken meanwhile, and its
// done cycle holds until the waiting result is accepted.
`timescale 1ns / 1ps
module ip_fragment_reassembly_tracker import ipfr_pkg::*; #(
	parameter int SLOTS      = 8,
	parameter int MAX_BLOCKS = 256,
	parameter int MAP_WORD   = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             opcode,
	input  logic [31:0]      src_addr,
	input  logic [31:0]      dst_addr,
	input  logic [7:0]       protocol,
	input  logic [12:0]      fragment_offset,
	input  logic [3:0]       header_words,
	input  logic [15:0]      total_length,
	input  logic             more_fragments,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       status,
	output logic [2:0]       entry_index,
	output logic [15:0]      data_length,
	output logic [15:0]      reassembled_length
);

	localparam int SW         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SLOT_WORDS = (MAX_BLOCKS + MAP_WORD - 1) / MAP_WORD;
	localparam int DEPTH      = SLOTS * SLOT_WORDS;
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WW         = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;

	state_t state_q, state_d;

	logic             op_q, mf_q;
	logic [31:0]      src_q, dst_q;
	logic [7:0]       proto_q;
	logic [12:0]      off_q;
	logic [HW_W-1:0]  hw_q;
	logic [15:0]      tlen_q;
	logic [SW-1:0]    slot_q;
	logic [BLK_W-1:0] lo_q, hi_q, chk_q, base_q;
	logic [WW:0]      w_q;
	logic             ok_q, vld_q;
	status_t          pend_q;
	logic [DEPTH-1:0] wv_q;

	logic             hit, free, cur_ls;
	logic [SW-1:0]    hit_idx, free_idx, slot_idx;
	logic [LEN_W-1:0] cur_pe;
	logic [HW_W-1:0]  cur_fhw;
	slot_ctl_t        ctl;

	logic             ld_in, ld_slot, set_pend, init_pass, advance, rd_issue, ram_we;
	logic [SW-1:0]    slot_d;
	status_t          pend_d;

	logic [16:0]      hw4, dl_ext, end_ext, full_ext;
	logic [15:0]      dl, end_sat, new_pe, pe_for_chk;
	logic [BLK_W-1:0] blocks, hi_d, chk_d, end_lim, chunks;
	logic             too_long, complete;
	logic [AW-1:0]    addr;
	logic [MAP_WORD-1:0] rdata, old_w, new_w, mask, need;

	ipfr_slots #(.SLOTS(SLOTS)) u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_addr (src_q),
		.dst_addr (dst_q),
		.protocol (proto_q),
		.hit      (hit),
		.hit_idx  (hit_idx),
		.free     (free),
		.free_idx (free_idx),
		.idx      (slot_idx),
		.ctl      (ctl),
		.pe       (cur_pe),
		.ls       (cur_ls),
		.fhw      (cur_fhw)
	);

	ipfr_ram #(.WIDTH(MAP_WORD), .DEPTH(DEPTH)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (new_w),
		.raddr (addr),
		.rdata (rdata)
	);

	// fragment geometry
	assign hw4     = {11'd0, hw_q, 2'b00};
	assign dl_ext  = ({1'b0, tlen_q} > hw4) ? ({1'b0, tlen_q} - hw4) : 17'd0;
	assign dl      = dl_ext[15:0];
	assign blocks  = BLK_W'(({1'b0, dl} + 17'd7) >> 3);
	assign hi_d    = BLK_W'(off_q) + blocks;
	assign too_long = hi_d > BLK_W'(MAX_BLOCKS);
	assign end_ext = {1'b0, off_q, 3'b000} + {1'b0, dl};
	assign end_sat = end_ext[16] ? 16'hFFFF : end_ext[15:0];
	assign new_pe  = (end_sat > cur_pe) ? end_sat : cur_pe;
	assign pe_for_chk = (op_q == OP_LOG) ? new_pe : cur_pe;
	assign chunks  = BLK_W'(({1'b0, pe_for_chk} + 17'd7) >> 3);
	assign chk_d   = (chunks > BLK_W'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS) : chunks;
	assign end_lim = (hi_q > chk_q) ? hi_q : chk_q;
	assign full_ext = {11'd0, cur_fhw, 2'b00} + {1'b0, cur_pe};
	assign complete = cur_ls && ok_q;

	assign slot_idx = ld_slot ? slot_d : slot_q;
	assign addr = AW'(int'(slot_q) * SLOT_WORDS + int'(w_q[WW-1:0]));

	// shared word unit: or-in the fragment mask and check required blocks
	assign old_w = vld_q ? rdata : '0;
	always_comb begin
		for (int i = 0; i < MAP_WORD; i++) begin
			mask[i] = ((base_q + BLK_W'(i)) >= lo_q) && ((base_q + BLK_W'(i)) < hi_q);
			need[i] = (base_q + BLK_W'(i)) < chk_q;
		end
	end
	assign new_w = old_w | mask;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ld_in     = 1'b0;
		ld_slot   = 1'b0;
		slot_d    = slot_q;
		set_pend  = 1'b0;
		pend_d    = pend_q;
		init_pass = 1'b0;
		advance   = 1'b0;
		rd_issue  = 1'b0;
		ram_we    = 1'b0;
		ctl       = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ld_in   = 1'b1;
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				if (op_q == OP_QUERY) begin
					if (hit) begin
						ld_slot = 1'b1;
						slot_d  = hit_idx;
						state_d = S_UPDATE;
					end else begin
						set_pend = 1'b1;
						pend_d   = STS_NOT_FOUND;
						state_d  = S_DONE;
					end
				end else if (!hit && !free) begin
					set_pend = 1'b1;
					pend_d   = STS_TABLE_FULL;
					state_d  = S_DONE;
				end else begin
					ld_slot   = 1'b1;
					slot_d    = hit ? hit_idx : free_idx;
					ctl.alloc = !hit;
					if (too_long) begin
						set_pend = 1'b1;
						pend_d   = STS_TOO_LONG;
						state_d  = S_DONE;
					end else begin
						state_d = S_UPDATE;
					end
				end
			end
			S_UPDATE: begin
				if (op_q == OP_LOG) begin
					ctl.set_pe  = 1'b1;
					ctl.pe_val  = new_pe;
					ctl.set_fhw = (off_q == 13'd0);
					ctl.fhw_val = hw_q;
					ctl.set_ls  = !mf_q;
				end
				init_pass = 1'b1;
				state_d   = S_RD;
			end
			S_RD: begin
				if (base_q >= end_lim) begin
					set_pend = 1'b1;
					if (op_q == OP_LOG) begin
						pend_d = complete ? STS_COMPLETE : STS_STORED;
					end else begin
						pend_d = complete ? STS_Q_COMPLETE : STS_NOT_COMPLETE;
					end
					state_d = S_DONE;
				end else if ((base_q + BLK_W'(MAP_WORD)) <= lo_q && base_q >= chk_q) begin
					advance = 1'b1;
				end else begin
					rd_issue = 1'b1;
					state_d  = S_WR;
				end
			end
			S_WR: begin
				ram_we  = 1'b1;
				advance = 1'b1;
				state_d = S_RD;
			end
			S_DONE: begin
				if (!out_valid || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_in) begin
			op_q    <= opcode;
			src_q   <= src_addr;
			dst_q   <= dst_addr;
			proto_q <= protocol;
			off_q   <= fragment_offset;
			hw_q    <= header_words;
			tlen_q  <= total_length;
			mf_q    <= more_fragments;
		end
		if (ld_slot) begin
			slot_q <= slot_d;
		end
		if (set_pend) begin
			pend_q <= pend_d;
		end
		if (init_pass) begin
			lo_q   <= (op_q == OP_LOG) ? BLK_W'(off_q) : '0;
			hi_q   <= (op_q == OP_LOG) ? hi_d : '0;
			chk_q  <= (cur_ls || (op_q == OP_LOG && !mf_q)) ? chk_d : '0;
			base_q <= '0;
			w_q    <= '0;
			ok_q   <= 1'b1;
		end
		if (advance) begin
			base_q <= base_q + BLK_W'(MAP_WORD);
			w_q    <= w_q + 1'b1;
		end
		if (rd_issue) begin
			vld_q <= wv_q[addr];
		end
		if (ram_we) begin
			ok_q <= ok_q && ((~new_w & need) == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wv_q <= '0;
		end else if (ctl.alloc) begin
			for (int j = 0; j < SLOT_WORDS; j++) begin
				wv_q[AW'(int'(slot_d) * SLOT_WORDS + j)] <= 1'b0;
			end
		end else if (ram_we) begin
			wv_q[addr] <= 1'b1;
		end
	end

	logic        no_slot;
	logic        has_len;
	logic [31:0] slot_ext;

	assign no_slot  = (pend_q == STS_TABLE_FULL) || (pend_q == STS_NOT_FOUND);
	assign has_len  = (pend_q == STS_COMPLETE) || (pend_q == STS_Q_COMPLETE);
	assign slot_ext = 32'(slot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid || out_ready)) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid || out_ready)) begin
			status             <= pend_q;
			entry_index        <= no_slot ? 3'd0 : slot_ext[2:0];
			data_length        <= no_slot ? 16'd0 : cur_pe;
			reassembled_length <= !has_len ? 16'd0 :
			                      (full_ext[16] ? 16'hFFFF : full_ext[15:0]);
		end
	end

	a_len_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STS_COMPLETE && status != STS_Q_COMPLETE
		|-> reassembled_length == 16'd0)
		else $error("reassembled length without completion");

	a_no_slot_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STS_TABLE_FULL || status == STS_NOT_FOUND)
		|-> entry_index == 3'd0 && data_length == 16'd0)
		else $error("slot fields set without a slot");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(rd_issue))
		else $error("bitmap write without preceding read");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready)
		else $error("item taken while busy");

endmodule

// File: hw/rtl/ipfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ipfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/ipfr_slots.sv
// Context slot table: keys, per-slot lengths and flags, key match and free-slot search.
`timescale 1ns / 1ps
module ipfr_slots import ipfr_pkg::*; #(
	parameter int SLOTS = 8,
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      src_addr,
	input  logic [31:0]      dst_addr,
	input  logic [7:0]       protocol,
	output logic             hit,
	output logic [SW-1:0]    hit_idx,
	output logic             free,
	output logic [SW-1:0]    free_idx,
	input  logic [SW-1:0]    idx,
	input  slot_ctl_t        ctl,
	output logic [LEN_W-1:0] pe,
	output logic             ls,
	output logic [HW_W-1:0]  fhw
);

	logic             valid_q [SLOTS];
	logic [31:0]      src_q   [SLOTS];
	logic [31:0]      dst_q   [SLOTS];
	logic [7:0]       proto_q [SLOTS];
	logic [LEN_W-1:0] pe_q    [SLOTS];
	logic             ls_q    [SLOTS];
	logic [HW_W-1:0]  fhw_q   [SLOTS];

	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free     = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (valid_q[i] && src_q[i] == src_addr && dst_q[i] == dst_addr &&
			    proto_q[i] == protocol) begin
				hit     = 1'b1;
				hit_idx = SW'(i);
			end
			if (!valid_q[i]) begin
				free     = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign pe  = pe_q[idx];
	assign ls  = ls_q[idx];
	assign fhw = fhw_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (ctl.alloc) begin
			valid_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.alloc) begin
			src_q[idx]   <= src_addr;
			dst_q[idx]   <= dst_addr;
			proto_q[idx] <= protocol;
			pe_q[idx]    <= '0;
			ls_q[idx]    <= 1'b0;
			fhw_q[idx]   <= '0;
		end else begin
			if (ctl.set_pe) begin
				pe_q[idx] <= ctl.pe_val;
			end
			if (ctl.set_fhw) begin
				fhw_q[idx] <= ctl.fhw_val;
			end
			if (ctl.set_ls) begin
				ls_q[idx] <= 1'b1;
			end
		end
	end

endmodule
